/* rtl/ouart_pkg.sv */
// Shared types and constants for the oversampled UART transceiver.
// Depends on nothing; imported by the top level and its port checker.
package ouart_pkg;

  // Request kinds carried on in_tuser.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2,
    CMD_POP   = 2'd3
  } cmd_t;

  // Receiver modes.
  typedef enum logic [1:0] {
    RX_HUNT = 2'd0,
    RX_DATA = 2'd1,
    RX_STOP = 2'd2
  } rx_mode_t;

  localparam int RING_DEPTH_DEF = 32;
  localparam int SEND_DEPTH_DEF = 32;

  localparam logic [2:0] PHASE_START = 3'd5;
  localparam logic [2:0] PHASE_BIT   = 3'd3;
  localparam logic [2:0] PHASE_RESET = 3'd2;

  localparam logic [3:0] DATA_BITS      = 4'd8;
  localparam logic [3:0] SLOT_LAST_DATA = 4'd8;
  localparam logic [3:0] SLOT_LAST_STOP = 4'd10;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

endpackage

/* rtl/oversampled_uart_transceiver.sv */
// Top level of the oversampled UART transceiver: transmitter, receiver,
// send store, receive ring and the result register. Depends on ouart_pkg.

// Every request completes in the cycle it is accepted, so the block takes one
// request per clock: in_tready stays high out of reset unless the result
// register holds a result that out_tready has not yet taken, and each result
// is registered. The transmitter sends 8 data bits LSB first framed by a start
// bit and two stop bits, then one idle slot, each slot lasting four tick
// requests unless the receiver, which shares the phase counter, reloads it to
// mid-bit on a low line while hunting; the receiver keeps a byte only if its
// stop sample is high. The send store holds SEND_DEPTH characters that read
// as spaces until written; its next character is fetched ahead into a register.
// Received bytes go into a ring of RING_DEPTH entries that holds at most
// RING_DEPTH-1 bytes and drops the oldest byte on overrun. The ring needs no
// clearing pass after reset, since only entries that were written are read.
module oversampled_uart_transceiver #(
  parameter int RING_DEPTH = ouart_pkg::RING_DEPTH_DEF,
  parameter int SEND_DEPTH = ouart_pkg::SEND_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: rx_pin[0], tx_index[5:1], tx_byte[13:6], tx_count[19:14].
  input  logic [23:0] in_tdata,
  // Fields from bit 0: command[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: tx_pin[0], rx_data[8:1], rx_valid[9], busy_res[10],
  // refused[11].
  output logic [15:0] out_tdata
);

  import ouart_pkg::*;

  localparam int SW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
  localparam int LW = $clog2(SEND_DEPTH + 1);
  localparam int RW = $clog2(RING_DEPTH);
  localparam logic [8:0] SEND_DEPTH_W = 9'(SEND_DEPTH);

  // Request fields.
  cmd_t       cmd;
  logic       rx_pin;
  logic [4:0] tx_index;
  logic [7:0] tx_byte;
  logic [5:0] tx_count;
  logic       accept;

  assign cmd      = cmd_t'(in_tuser);
  assign rx_pin   = in_tdata[0];
  assign tx_index = in_tdata[5:1];
  assign tx_byte  = in_tdata[13:6];
  assign tx_count = in_tdata[19:14];

  // Transmitter state.
  logic          line_r, line_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          sending_r, sending_nxt;
  logic [SW-1:0] pos_r, pos_nxt;
  logic [3:0]    slot_r, slot_nxt;
  logic [7:0]    tshift_r, tshift_nxt;

  // Receiver state.
  logic [2:0]    phase_r, phase_nxt;
  rx_mode_t      mode_r, mode_nxt;
  logic [7:0]    rshift_r, rshift_nxt;
  logic [3:0]    rbits_r, rbits_nxt;
  logic [RW-1:0] head_r, head_nxt;
  logic [RW-1:0] tail_r, tail_nxt;

  // Send store with per-entry written flags and a fetch-ahead register.
  logic [7:0]            st_mem [SEND_DEPTH];
  logic [SEND_DEPTH-1:0] vld_r;
  logic [7:0]            q_r;
  logic                  st_we;
  logic [SW-1:0]         st_waddr;

  // Receive ring.
  logic [7:0] ring_mem [RING_DEPTH];
  logic       ring_we;
  logic       ring_rd;

  // Result register.
  logic       out_valid_r;
  logic       out_line_r, out_line_nxt;
  logic       out_rvalid_r, out_rvalid_nxt;
  logic       out_busy_r, out_busy_nxt;
  logic       out_refused_r, out_refused_nxt;
  logic [7:0] rdata_r;

  function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] v);
    ring_inc = (v == RW'(RING_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    logic [8:0] idx9;
    logic [8:0] cnt9;
    logic [8:0] len9;
    logic [8:0] next9;
    logic [3:0] bits_inc;
    idx9     = {4'b0, tx_index};
    cnt9     = {3'b0, tx_count};
    len9     = (cnt9 > SEND_DEPTH_W) ? SEND_DEPTH_W : cnt9;
    next9    = 9'(pos_r) + 9'd1;
    bits_inc = 4'd0;

    line_nxt        = line_r;
    len_nxt         = len_r;
    sending_nxt     = sending_r;
    pos_nxt         = pos_r;
    slot_nxt        = slot_r;
    tshift_nxt      = tshift_r;
    phase_nxt       = phase_r;
    mode_nxt        = mode_r;
    rshift_nxt      = rshift_r;
    rbits_nxt       = rbits_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    st_we           = 1'b0;
    st_waddr        = idx9[SW-1:0];
    ring_we         = 1'b0;
    ring_rd         = 1'b0;
    out_rvalid_nxt  = 1'b0;
    out_refused_nxt = 1'b0;

    if (accept) begin
      case (cmd)
        CMD_TICK: begin
          // The transmitter acts on the phase left by the previous tick.
          if (phase_r == 3'd0) begin
            if (slot_r == 4'd0) begin
              if (sending_r) begin
                if (9'(pos_r) < 9'(len_r)) begin
                  line_nxt   = 1'b0;
                  tshift_nxt = q_r;
                end
                slot_nxt = 4'd1;
              end
            end else if (slot_r inside {[4'd1:SLOT_LAST_DATA]}) begin
              line_nxt   = tshift_r[0];
              tshift_nxt = {1'b0, tshift_r[7:1]};
              slot_nxt   = slot_r + 4'd1;
            end else if (slot_r <= SLOT_LAST_STOP) begin
              line_nxt = 1'b1;
              slot_nxt = slot_r + 4'd1;
            end else begin
              slot_nxt = 4'd0;
              if (next9 >= 9'(len_r)) begin
                sending_nxt = 1'b0;
                pos_nxt     = '0;
              end else begin
                pos_nxt = next9[SW-1:0];
              end
            end
          end

          // A low line while hunting starts a frame and recenters the phase.
          if (mode_r == RX_HUNT && !rx_pin) begin
            rbits_nxt = 4'd0;
            mode_nxt  = RX_DATA;
            phase_nxt = PHASE_START;
          end
          if (phase_nxt != 3'd0) begin
            phase_nxt = phase_nxt - 3'd1;
          end else begin
            phase_nxt = PHASE_BIT;
            case (mode_nxt)
              RX_DATA: begin
                bits_inc   = rbits_nxt + 4'd1;
                rshift_nxt = {rx_pin, rshift_r[7:1]};
                rbits_nxt  = bits_inc;
                if (bits_inc >= DATA_BITS) begin
                  mode_nxt = RX_STOP;
                end
              end
              RX_STOP: begin
                if (rx_pin) begin
                  ring_we  = 1'b1;
                  head_nxt = ring_inc(head_r);
                  if (ring_inc(head_r) == tail_r) begin
                    tail_nxt = ring_inc(tail_r);
                  end
                end
                mode_nxt = RX_HUNT;
              end
              default: ;
            endcase
          end
        end
        CMD_WRITE: begin
          if (sending_r) begin
            out_refused_nxt = 1'b1;
          end else if (idx9 < SEND_DEPTH_W) begin
            st_we = 1'b1;
          end
        end
        CMD_START: begin
          if (sending_r || tx_count == 6'd0) begin
            out_refused_nxt = 1'b1;
          end else begin
            len_nxt     = len9[LW-1:0];
            sending_nxt = 1'b1;
            pos_nxt     = '0;
            slot_nxt    = 4'd0;
          end
        end
        CMD_POP: begin
          if (head_r != tail_r) begin
            ring_rd        = 1'b1;
            out_rvalid_nxt = 1'b1;
            tail_nxt       = ring_inc(tail_r);
          end
        end
        default: ;
      endcase
    end

    out_line_nxt = line_nxt;
    out_busy_nxt = sending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r        <= 1'b1;
      len_r         <= LW'(SEND_DEPTH);
      sending_r     <= 1'b0;
      pos_r         <= '0;
      slot_r        <= 4'd0;
      tshift_r      <= 8'd0;
      phase_r       <= PHASE_RESET;
      mode_r        <= RX_HUNT;
      rshift_r      <= 8'd0;
      rbits_r       <= 4'd0;
      head_r        <= '0;
      tail_r        <= '0;
      vld_r         <= '0;
      out_valid_r   <= 1'b0;
      out_line_r    <= 1'b1;
      out_rvalid_r  <= 1'b0;
      out_busy_r    <= 1'b0;
      out_refused_r <= 1'b0;
    end else begin
      line_r    <= line_nxt;
      len_r     <= len_nxt;
      sending_r <= sending_nxt;
      pos_r     <= pos_nxt;
      slot_r    <= slot_nxt;
      tshift_r  <= tshift_nxt;
      phase_r   <= phase_nxt;
      mode_r    <= mode_nxt;
      rshift_r  <= rshift_nxt;
      rbits_r   <= rbits_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      if (st_we) begin
        vld_r[st_waddr] <= 1'b1;
      end
      if (accept) begin
        out_valid_r   <= 1'b1;
        out_line_r    <= out_line_nxt;
        out_rvalid_r  <= out_rvalid_nxt;
        out_busy_r    <= out_busy_nxt;
        out_refused_r <= out_refused_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Send store: write port plus a fetch of the character at the next
  // position, with write bypass and spaces for entries never written.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= tx_byte;
    end
    if (!rst_n) begin
      q_r <= SPACE_CHAR;
    end else if (st_we && st_waddr == pos_nxt) begin
      q_r <= tx_byte;
    end else if (vld_r[pos_nxt]) begin
      q_r <= st_mem[pos_nxt];
    end else begin
      q_r <= SPACE_CHAR;
    end
  end

  // Receive ring: push at the head, pop at the tail into the result register.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[head_r] <= rshift_r;
    end
    if (ring_rd) begin
      rdata_r <= ring_mem[tail_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_refused_r, out_busy_r, out_rvalid_r,
                       (out_rvalid_r ? rdata_r : 8'h00), out_line_r};

endmodule

/* rtl/ouart_checker.sv */
// Port-level checker for the oversampled UART transceiver, with its bind.
// Depends on ouart_pkg and the top level oversampled_uart_transceiver.
module ouart_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  import ouart_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // A result that is not taken holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every accepted request shows its result on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted request produced no result");

  // A tick is never refused and never returns a received byte.
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == CMD_TICK |=> !out_tdata[11] && !out_tdata[9])
    else $error("tick result flagged refused or valid");

  // A start with zero length is refused.
  a_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == CMD_START && in_tdata[19:14] == 6'd0 |=> out_tdata[11])
    else $error("zero-length start was not refused");

  // A nonzero start leaves the transmitter busy, whether taken or refused.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == CMD_START && in_tdata[19:14] != 6'd0 |=> out_tdata[10])
    else $error("start left the transmitter idle");

endmodule

bind oversampled_uart_transceiver ouart_checker u_ouart_checker (.*);
